// ===== sv/cst_pkg.sv =====
// Shared types and constants of the counting semaphore table.
package cst_pkg;

	localparam int NUM_SEMAPHORES_DEF = 256;
	localparam int NUM_PROCESSES_DEF  = 16;
	localparam int COUNT_WIDTH_DEF    = 16;

	localparam int ACT_W   = 3;
	localparam int KEY_W   = 8;
	localparam int PID_W   = 4;
	localparam int START_W = 8;
	localparam int STS_W   = 2;

	localparam logic [ACT_W-1:0] ACT_CREATE  = 3'd0;
	localparam logic [ACT_W-1:0] ACT_DESTROY = 3'd1;
	localparam logic [ACT_W-1:0] ACT_DOWN    = 3'd2;
	localparam logic [ACT_W-1:0] ACT_UP      = 3'd3;
	localparam logic [ACT_W-1:0] ACT_RELEASE = 3'd4;

	localparam logic [STS_W-1:0] STS_OK      = 2'd0;
	localparam logic [STS_W-1:0] STS_QUEUED  = 2'd1;
	localparam logic [STS_W-1:0] STS_NOFREE  = 2'd2;
	localparam logic [STS_W-1:0] STS_IGNORED = 2'd3;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_DECODE,
		S_READ,
		S_EXEC,
		S_SCAN_RD,
		S_SCAN_CHK,
		S_UNL_RD,
		S_UNL_INIT,
		S_WALK,
		S_DONE
	} state_t;

	typedef struct packed {
		logic clr;
		logic load;
		logic rd_key;
		logic exec;
		logic scan_rd;
		logic scan_chk;
		logic unl_rd;
		logic unl_init;
		logic walk;
		logic respond;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic is_create;
		logic is_release;
		logic is_keyed;
		logic key_ok;
		logic hit;
		logic slot_last;
		logic need_unlink;
		logic walk_done;
	} sts_t;

endpackage

// ===== sv/cst_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module cst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== sv/cst_datapath.sv =====
// Datapath: semaphore table memory, per-process wait links and result registers.
module cst_datapath import cst_pkg::*; #(
	parameter int NUM_SEMAPHORES = NUM_SEMAPHORES_DEF,
	parameter int NUM_PROCESSES  = NUM_PROCESSES_DEF,
	parameter int COUNT_WIDTH    = COUNT_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	output sts_t               sts,
	input  logic [ACT_W-1:0]   action,
	input  logic [KEY_W-1:0]   sem_key,
	input  logic [PID_W-1:0]   process_id,
	input  logic [START_W-1:0] start_count,
	output logic [STS_W-1:0]   status,
	output logic [KEY_W-1:0]   created_key,
	output logic               woken_valid,
	output logic [PID_W-1:0]   woken_process
);

	localparam int PI_W    = $clog2(NUM_PROCESSES + 1);
	localparam int PIX_W   = $clog2(NUM_PROCESSES);
	localparam int SK_W    = $clog2(NUM_SEMAPHORES);
	localparam int WO_W    = $clog2(NUM_SEMAPHORES + 1);
	localparam int NB_W    = $clog2(NUM_PROCESSES + 1);
	localparam int CW      = COUNT_WIDTH;
	localparam int HEAD_LO = PI_W;
	localparam int CNT_LO  = 2 * PI_W;
	localparam int OWN_LO  = CNT_LO + CW;
	localparam int USE_BIT = OWN_LO + PID_W;
	localparam int WORD_W  = USE_BIT + 1;

	localparam logic [PI_W-1:0] NONE   = PI_W'(NUM_PROCESSES);
	localparam logic [WO_W-1:0] NOTW   = WO_W'(NUM_SEMAPHORES);
	localparam logic [CW-1:0]   CNTMAX = '1;

	logic [ACT_W-1:0]   act_q;
	logic [KEY_W-1:0]   key_q;
	logic [PID_W-1:0]   pid_q;
	logic [START_W-1:0] start_q;
	logic [SK_W-1:0]    slot_q, clr_q, s_q;
	logic [PI_W-1:0]    cur_q, prev_q;
	logic [NB_W-1:0]    n_q;
	logic [WORD_W-1:0]  word_q;
	logic [PI_W-1:0]    wn_q [NUM_PROCESSES];
	logic [WO_W-1:0]    wo_q [NUM_PROCESSES];

	logic               ram_we;
	logic [SK_W-1:0]    ram_waddr, ram_raddr;
	logic [WORD_W-1:0]  ram_wdata, rdata;

	logic               r_use;
	logic [PID_W-1:0]   r_own;
	logic [CW-1:0]      r_cnt;
	logic [PI_W-1:0]    r_head, r_tail, q_head, q_tail;
	logic               pid_ok;
	logic [PIX_W-1:0]   pid_ix, wn_raddr;
	logic [WO_W-1:0]    wo_pid;
	logic [PI_W-1:0]    wn_rd;
	logic [STS_W-1:0]   ex_sts;
	logic               dn_enq, link_tail, up_wake, walk_end, found, hit;
	logic [PI_W-1:0]    n_head, n_tail;

	assign r_tail = rdata[HEAD_LO-1:0];
	assign r_head = rdata[CNT_LO-1:HEAD_LO];
	assign r_cnt  = rdata[OWN_LO-1:CNT_LO];
	assign r_own  = rdata[USE_BIT-1:OWN_LO];
	assign r_use  = rdata[USE_BIT];
	assign q_tail = word_q[HEAD_LO-1:0];
	assign q_head = word_q[CNT_LO-1:HEAD_LO];

	assign pid_ok   = int'(pid_q) < NUM_PROCESSES;
	assign pid_ix   = PIX_W'(pid_q);
	assign wo_pid   = wo_q[pid_ix];
	assign wn_raddr = cmd.walk ? PIX_W'(cur_q) : PIX_W'(r_head);
	assign wn_rd    = wn_q[wn_raddr];
	assign hit      = !r_use;

	assign walk_end = (n_q == NB_W'(NUM_PROCESSES)) || (cur_q >= NONE);
	assign found    = !walk_end && (cur_q == PI_W'(pid_q));

	assign sts.clr_last    = clr_q == SK_W'(NUM_SEMAPHORES - 1);
	assign sts.is_create   = act_q == ACT_CREATE;
	assign sts.is_release  = act_q == ACT_RELEASE;
	assign sts.is_keyed    = (act_q == ACT_DESTROY) || (act_q == ACT_DOWN) || (act_q == ACT_UP);
	assign sts.key_ok      = int'(key_q) < NUM_SEMAPHORES;
	assign sts.hit         = hit;
	assign sts.slot_last   = slot_q == SK_W'(NUM_SEMAPHORES - 1);
	assign sts.need_unlink = pid_ok && (wo_pid < NOTW);
	assign sts.walk_done   = walk_end || found;

	always_comb begin
		ram_raddr = slot_q;
		if (cmd.rd_key) begin
			ram_raddr = SK_W'(key_q);
		end else if (cmd.unl_rd) begin
			ram_raddr = SK_W'(wo_pid);
		end
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = SK_W'(key_q);
		ram_wdata = rdata;
		ex_sts    = STS_IGNORED;
		dn_enq    = 1'b0;
		link_tail = 1'b0;
		up_wake   = 1'b0;
		n_head    = r_head;
		n_tail    = r_tail;
		if (cmd.clr) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = {clr_q == '0, PID_W'(0), CW'(0), NONE, NONE};
		end else if (cmd.exec) begin
			case (act_q)
				ACT_DESTROY: begin
					if (key_q != '0 && r_own == pid_q) begin
						ram_we    = 1'b1;
						ram_wdata = {1'b0, r_own, r_cnt, r_head, r_tail};
						ex_sts    = STS_OK;
					end
				end
				ACT_DOWN: begin
					if (r_cnt != '0) begin
						ram_we    = 1'b1;
						ram_wdata = {r_use, r_own, r_cnt - CW'(1), r_head, r_tail};
						ex_sts    = STS_OK;
					end else if (pid_ok) begin
						ex_sts = STS_QUEUED;
						if (wo_pid == NOTW) begin
							dn_enq    = 1'b1;
							link_tail = !(r_head >= NONE || r_tail >= NONE);
							n_head    = link_tail ? r_head : PI_W'(pid_q);
							n_tail    = PI_W'(pid_q);
							ram_we    = 1'b1;
							ram_wdata = {r_use, r_own, r_cnt, n_head, n_tail};
						end
					end
				end
				ACT_UP: begin
					ex_sts = STS_OK;
					if (r_head < NONE) begin
						up_wake   = 1'b1;
						n_head    = (wn_rd >= NONE) ? NONE : wn_rd;
						n_tail    = (wn_rd >= NONE) ? NONE : r_tail;
						ram_we    = 1'b1;
						ram_wdata = {r_use, r_own, r_cnt, n_head, n_tail};
					end else if (r_cnt != CNTMAX) begin
						ram_we    = 1'b1;
						ram_wdata = {r_use, r_own, r_cnt + CW'(1), r_head, r_tail};
					end
				end
				default: begin
					ex_sts = STS_IGNORED;
				end
			endcase
		end else if (cmd.scan_chk) begin
			ram_waddr = slot_q;
			if (sts.is_create) begin
				ram_we    = hit;
				ram_wdata = {1'b1, pid_q, CW'(start_q), NONE, NONE};
			end else begin
				ram_we    = r_own == pid_q;
				ram_wdata = {1'b0, r_own, r_cnt, r_head, r_tail};
			end
		end else if (cmd.walk) begin
			ram_waddr = s_q;
			ram_we    = sts.walk_done;
			n_head    = (found && prev_q == NONE) ? wn_rd : q_head;
			n_tail    = (found && q_tail == PI_W'(pid_q)) ? prev_q : q_tail;
			ram_wdata = {word_q[WORD_W-1:CNT_LO], n_head, n_tail};
		end
	end

	cst_ram #(
		.WIDTH(WORD_W),
		.DEPTH(NUM_SEMAPHORES)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr) begin
			clr_q <= clr_q + SK_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q   <= action;
			key_q   <= sem_key;
			pid_q   <= process_id;
			start_q <= start_count;
			slot_q  <= SK_W'(1);
		end else if (cmd.scan_chk) begin
			slot_q <= slot_q + SK_W'(1);
		end
		if (cmd.unl_rd) begin
			s_q <= SK_W'(wo_pid);
		end
		if (cmd.unl_init) begin
			word_q <= rdata;
			cur_q  <= r_head;
			prev_q <= NONE;
			n_q    <= '0;
		end else if (cmd.walk) begin
			prev_q <= cur_q;
			cur_q  <= wn_rd;
			n_q    <= n_q + NB_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			status        <= (action == ACT_CREATE) ? STS_NOFREE :
			                 (action == ACT_RELEASE) ? STS_OK : STS_IGNORED;
			created_key   <= '0;
			woken_valid   <= 1'b0;
			woken_process <= '0;
		end else if (cmd.exec) begin
			status        <= ex_sts;
			woken_valid   <= up_wake;
			woken_process <= up_wake ? PID_W'(r_head) : '0;
		end else if (cmd.scan_chk && sts.is_create && hit) begin
			status      <= STS_OK;
			created_key <= KEY_W'(slot_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < NUM_PROCESSES; p++) begin
				wn_q[p] <= NONE;
				wo_q[p] <= NOTW;
			end
		end else begin
			if (cmd.scan_chk && sts.is_create && hit) begin
				for (int p = 0; p < NUM_PROCESSES; p++) begin
					if (wo_q[p] == WO_W'(slot_q)) begin
						wo_q[p] <= NOTW;
						wn_q[p] <= NONE;
					end
				end
			end
			if (cmd.exec && dn_enq) begin
				wn_q[pid_ix] <= NONE;
				if (link_tail) begin
					wn_q[PIX_W'(r_tail)] <= PI_W'(pid_q);
				end
				wo_q[pid_ix] <= WO_W'(key_q);
			end
			if (cmd.exec && up_wake) begin
				wn_q[PIX_W'(r_head)] <= NONE;
				wo_q[PIX_W'(r_head)] <= NOTW;
			end
			if (cmd.walk && found && prev_q != NONE) begin
				wn_q[PIX_W'(prev_q)] <= wn_rd;
			end
			if (cmd.walk && sts.walk_done) begin
				wn_q[pid_ix] <= NONE;
				wo_q[pid_ix] <= NOTW;
			end
		end
	end

endmodule

// ===== sv/cst_ctrl.sv =====
// Controller state machine that sequences the semaphore table datapath.
module cst_ctrl import cst_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  sts_t sts,
	output cmd_t cmd,
	output logic busy,
	output logic done
);

	state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			S_CLEAR: begin
				if (sts.clr_last) state_nx = S_IDLE;
			end
			S_IDLE: begin
				if (start) state_nx = S_DECODE;
			end
			S_DECODE: begin
				if (sts.is_create || sts.is_release) state_nx = S_SCAN_RD;
				else if (sts.is_keyed && sts.key_ok) state_nx = S_READ;
				else state_nx = S_DONE;
			end
			S_READ:     state_nx = S_EXEC;
			S_EXEC:     state_nx = S_DONE;
			S_SCAN_RD:  state_nx = S_SCAN_CHK;
			S_SCAN_CHK: begin
				if (sts.is_create && sts.hit) state_nx = S_DONE;
				else if (sts.slot_last) begin
					state_nx = (sts.is_release && sts.need_unlink) ? S_UNL_RD : S_DONE;
				end else state_nx = S_SCAN_RD;
			end
			S_UNL_RD:   state_nx = S_UNL_INIT;
			S_UNL_INIT: state_nx = S_WALK;
			S_WALK: begin
				if (sts.walk_done) state_nx = S_DONE;
			end
			S_DONE:     state_nx = S_IDLE;
			default:    state_nx = S_IDLE;
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		done = 1'b0;
		case (state_q)
			S_CLEAR:    cmd.clr = 1'b1;
			S_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			S_READ:     cmd.rd_key = 1'b1;
			S_EXEC:     cmd.exec = 1'b1;
			S_SCAN_RD:  cmd.scan_rd = 1'b1;
			S_SCAN_CHK: cmd.scan_chk = 1'b1;
			S_UNL_RD:   cmd.unl_rd = 1'b1;
			S_UNL_INIT: cmd.unl_init = 1'b1;
			S_WALK:     cmd.walk = 1'b1;
			S_DONE: begin
				cmd.respond = 1'b1;
				done        = 1'b1;
			end
			default:    cmd = '0;
		endcase
	end

endmodule

// ===== sv/counting_semaphore_table_top.sv =====
// Top level of the counting semaphore table with FIFO wait queues.
//
// Usage: a request (action, sem_key, process_id, start_count) is transferred at a
// rising clock edge where start is high and busy is low. Exactly one result per
// request follows: status, created_key, woken_valid and woken_process are valid
// for the single cycle in which done is high, and that cycle ends the transfer.
// The receiver cannot hold results off; busy stays high until done has been shown.
// Destroy, down and up pass through the decode, read, execute and done states after
// the accepting edge, and undefined actions through the decode and done states.
// Create and release walk the slot table through the memory's single read port,
// with a read and a check state per slot from slot 1: create stops at the lowest
// free slot, release scans up to slot NUM_SEMAPHORES-1, and when the process must
// leave a wait queue, unlink read and init states and a walk state per entry follow.
// One request is worked on at a time.
// Reset: after arst_n is released a clearing pass writes every one of the
// NUM_SEMAPHORES table entries, one per cycle, with busy high; then the block idles.
module counting_semaphore_table_top import cst_pkg::*; #(
	parameter int NUM_SEMAPHORES = NUM_SEMAPHORES_DEF,
	parameter int NUM_PROCESSES  = NUM_PROCESSES_DEF,
	parameter int COUNT_WIDTH    = COUNT_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [ACT_W-1:0]   action,
	input  logic [KEY_W-1:0]   sem_key,
	input  logic [PID_W-1:0]   process_id,
	input  logic [START_W-1:0] start_count,
	output logic               done,
	output logic [STS_W-1:0]   status,
	output logic [KEY_W-1:0]   created_key,
	output logic               woken_valid,
	output logic [PID_W-1:0]   woken_process
);

	// Command and status groups between the sequencer and the datapath.
	cmd_t cmd;
	sts_t sts;

	cst_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.sts   (sts),
		.cmd   (cmd),
		.busy  (busy),
		.done  (done)
	);

	// The datapath holds the table memory, the wait links and the result registers.
	cst_datapath #(
		.NUM_SEMAPHORES(NUM_SEMAPHORES),
		.NUM_PROCESSES (NUM_PROCESSES),
		.COUNT_WIDTH   (COUNT_WIDTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.action       (action),
		.sem_key      (sem_key),
		.process_id   (process_id),
		.start_count  (start_count),
		.status       (status),
		.created_key  (created_key),
		.woken_valid  (woken_valid),
		.woken_process(woken_process)
	);

	// An accepted request keeps the block busy until its result is shown.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy && !done)
		else $error("block not busy after a request transfer");

	// A result is shown for one cycle only.
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	// A woken process is only ever reported with a plain success status.
	a_wake_ok: assert property (@(posedge clk) disable iff (!arst_n)
		done && woken_valid |-> status == STS_OK)
		else $error("wake reported with a non-success status");

	// A create without a free slot reports key zero.
	a_nofree_key: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == STS_NOFREE |-> created_key == '0)
		else $error("nonzero key with no free semaphore");

endmodule

// ===== bench/semaphore_table_checker.sv =====
// Checker that predicts and compares the results of the counting semaphore table.
`timescale 1ns / 1ps
module semaphore_table_checker import cst_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic [ACT_W-1:0]   action,
	input  logic [KEY_W-1:0]   sem_key,
	input  logic [PID_W-1:0]   process_id,
	input  logic [START_W-1:0] start_count,
	input  logic               done,
	input  logic [STS_W-1:0]   status,
	input  logic [KEY_W-1:0]   created_key,
	input  logic               woken_valid,
	input  logic [PID_W-1:0]   woken_process,
	output int                 fail_count,
	output int                 pending,
	output int                 checked
);
	localparam int NSEM = NUM_SEMAPHORES_DEF;
	localparam int NPROC = NUM_PROCESSES_DEF;
	localparam int CMAX = (1 << COUNT_WIDTH_DEF) - 1;

	typedef struct packed {
		logic [STS_W-1:0] sts;
		logic [KEY_W-1:0] ckey;
		logic             wv;
		logic [PID_W-1:0] wp;
	} reply_t;

	int count_of[NSEM];
	bit used[NSEM];
	int owner_of[NSEM];
	int head[NSEM];
	int tail[NSEM];
	int next_waiter[NPROC];
	int blocked_on[NPROC];
	reply_t replies_due[$];

	// Takes a process out of the wait list of one semaphore.
	function automatic void drop_waiter(int s, int pid);
		int prev, cur, nxt;
		prev = NPROC;
		cur = head[s];
		for (int n = 0; n < NPROC && cur < NPROC; n++) begin
			nxt = next_waiter[cur];
			if (cur == pid) begin
				if (prev == NPROC) head[s] = nxt;
				else next_waiter[prev] = nxt;
				if (tail[s] == pid) tail[s] = prev;
				break;
			end
			prev = cur;
			cur = nxt;
		end
		next_waiter[pid] = NPROC;
		blocked_on[pid] = NSEM;
	endfunction

	function automatic reply_t run_request(logic [ACT_W-1:0] a, int k, int pid, int cnt);
		reply_t r;
		int h;
		r = '{sts: STS_IGNORED, ckey: '0, wv: 1'b0, wp: '0};
		case (a)
			ACT_CREATE: begin
				r.sts = STS_NOFREE;
				for (int s = 1; s < NSEM; s++) begin
					if (!used[s]) begin
						used[s] = 1'b1;
						owner_of[s] = pid;
						count_of[s] = cnt;
						head[s] = NPROC;
						tail[s] = NPROC;
						// Stale waiters on the reclaimed slot are dropped silently.
						for (int p = 0; p < NPROC; p++) begin
							if (blocked_on[p] == s) begin
								blocked_on[p] = NSEM;
								next_waiter[p] = NPROC;
							end
						end
						r.sts = STS_OK;
						r.ckey = s[KEY_W-1:0];
						break;
					end
				end
			end
			ACT_DESTROY: begin
				if (k != 0 && owner_of[k] == pid) begin
					used[k] = 1'b0;
					r.sts = STS_OK;
				end
			end
			ACT_DOWN: begin
				if (count_of[k] != 0) begin
					count_of[k]--;
					r.sts = STS_OK;
				end else begin
					if (blocked_on[pid] == NSEM) begin
						next_waiter[pid] = NPROC;
						if (head[k] >= NPROC || tail[k] >= NPROC) head[k] = pid;
						else next_waiter[tail[k]] = pid;
						tail[k] = pid;
						blocked_on[pid] = k;
					end
					r.sts = STS_QUEUED;
				end
			end
			ACT_UP: begin
				h = head[k];
				r.sts = STS_OK;
				if (h < NPROC) begin
					head[k] = next_waiter[h];
					if (head[k] >= NPROC) begin
						head[k] = NPROC;
						tail[k] = NPROC;
					end
					next_waiter[h] = NPROC;
					blocked_on[h] = NSEM;
					r.wv = 1'b1;
					r.wp = h[PID_W-1:0];
				end else if (count_of[k] < CMAX) begin
					count_of[k]++;
				end
			end
			ACT_RELEASE: begin
				for (int s = 1; s < NSEM; s++)
					if (owner_of[s] == pid) used[s] = 1'b0;
				if (blocked_on[pid] < NSEM) drop_waiter(blocked_on[pid], pid);
				r.sts = STS_OK;
			end
			default: ;
		endcase
		return r;
	endfunction

	initial begin
		for (int s = 0; s < NSEM; s++) begin
			count_of[s] = 0;
			used[s] = (s == 0);
			owner_of[s] = 0;
			head[s] = NPROC;
			tail[s] = NPROC;
		end
		for (int p = 0; p < NPROC; p++) begin
			next_waiter[p] = NPROC;
			blocked_on[p] = NSEM;
		end
		fail_count = 0;
		checked = 0;
	end

	assign pending = replies_due.size();

	always @(posedge clk) begin
		reply_t want;
		if (arst_n && start && !busy)
			replies_due.push_back(run_request(action, sem_key, process_id, start_count));
		if (arst_n && done) begin
			checked++;
			if (replies_due.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("unexpected result: status %0d key %0d woken %0d/%0d",
						status, created_key, woken_valid, woken_process);
			end else begin
				want = replies_due.pop_front();
				if (status !== want.sts || created_key !== want.ckey ||
						woken_valid !== want.wv || woken_process !== want.wp) begin
					fail_count++;
					if (fail_count <= 10)
						$display("mismatch: status %0d/%0d key %0d/%0d woken %0d/%0d proc %0d/%0d",
							want.sts, status, want.ckey, created_key,
							want.wv, woken_valid, want.wp, woken_process);
				end
			end
		end
	end
endmodule

// ===== bench/counting_semaphore_table_top_test.sv =====
// Stimulus and verdict for the counting semaphore table.
`timescale 1ns / 1ps
module counting_semaphore_table_top_test;
	import cst_pkg::*;

	// Action codes above release are undefined and must be ignored.
	localparam logic [ACT_W-1:0] ACT_UNDEF_LO = 3'd5;
	localparam logic [ACT_W-1:0] ACT_UNDEF_HI = 3'd7;
	localparam int CYCLE_LIMIT = 3000000;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic [ACT_W-1:0]   action = '0;
	logic [KEY_W-1:0]   sem_key = '0;
	logic [PID_W-1:0]   process_id = '0;
	logic [START_W-1:0] start_count = '0;
	logic               done;
	logic [STS_W-1:0]   status;
	logic [KEY_W-1:0]   created_key;
	logic               woken_valid;
	logic [PID_W-1:0]   woken_process;
	int                 fail_count, pending, checked;

	// Percent chance per roll that the sender idles before each transfer; it rolls again until it sends.
	int idle_pct = 0;
	int issued = 0;
	int cycles = 0;
	// Keys handed out by recent creates, so that most requests hit live slots.
	logic [KEY_W-1:0] live_keys[$];

	always #2 clk = ~clk;

	counting_semaphore_table_top uut (
		.clk, .arst_n, .start, .busy, .action, .sem_key, .process_id, .start_count,
		.done, .status, .created_key, .woken_valid, .woken_process
	);

	semaphore_table_checker checker_i (
		.clk, .arst_n, .start, .busy, .action, .sem_key, .process_id, .start_count,
		.done, .status, .created_key, .woken_valid, .woken_process,
		.fail_count, .pending, .checked
	);

	// The watchdog ends a hung run; even if every request were a full table
	// scan with a queue walk, the run stays well inside this limit.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("[counting_semaphore_table_top] ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && done && status == STS_OK && created_key != 0) begin
			live_keys.push_back(created_key);
			if (live_keys.size() > 6) void'(live_keys.pop_front());
		end
	end

	// Drives one request and holds it until the block takes the transfer.
	task automatic send(logic [ACT_W-1:0] a, logic [KEY_W-1:0] k,
			logic [PID_W-1:0] p, logic [START_W-1:0] c);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		action <= a;
		sem_key <= k;
		process_id <= p;
		start_count <= c;
		@(posedge clk);
		while (busy) @(posedge clk);
		issued++;
	endtask

	// Drops start and waits so that the last transfer is counted, then until all results are in.
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic random_request();
		logic [ACT_W-1:0] a;
		logic [KEY_W-1:0] k;
		int roll;
		roll = $urandom_range(99);
		if (roll < 16) a = ACT_CREATE;
		else if (roll < 30) a = ACT_DESTROY;
		else if (roll < 60) a = ACT_DOWN;
		else if (roll < 94) a = ACT_UP;
		else if (roll < 97) a = ACT_RELEASE;
		else a = ACT_W'(ACT_UNDEF_LO + $urandom_range(ACT_UNDEF_HI - ACT_UNDEF_LO));
		roll = $urandom_range(99);
		if (roll < 75 && live_keys.size() != 0)
			k = live_keys[$urandom_range(live_keys.size() - 1)];
		else if (roll < 90) k = KEY_W'($urandom_range(8));
		else k = KEY_W'($urandom_range(255));
		// A narrow range of processes makes queues and owner matches common.
		send(a, k,
			PID_W'(($urandom_range(3) == 0) ? $urandom_range(15) : $urandom_range(4)),
			START_W'(($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(2)));
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: extremes of the fields and every action.
		send(ACT_CREATE, 8'd0, 4'd15, 8'd255);
		send(ACT_CREATE, 8'd0, 4'd0, 8'd0);
		send(ACT_DOWN, 8'd2, 4'd3, 8'd0);
		send(ACT_DOWN, 8'd2, 4'd3, 8'd0);
		send(ACT_DOWN, 8'd2, 4'd15, 8'd0);
		send(ACT_UP, 8'd2, 4'd0, 8'd0);
		send(ACT_DESTROY, 8'd1, 4'd0, 8'd0);
		send(ACT_DESTROY, 8'd0, 4'd0, 8'd0);
		send(ACT_DESTROY, 8'd255, 4'd0, 8'd0);
		send(ACT_DOWN, 8'd255, 4'd7, 8'd0);
		send(ACT_UP, 8'd255, 4'd8, 8'd0);
		send(ACT_DESTROY, 8'd2, 4'd0, 8'd0);
		// Slot 2 is now free with process 15 still queued on it; the next
		// create reclaims it and drops that stale waiter.
		send(ACT_CREATE, 8'd0, 4'd5, 8'd0);
		send(ACT_UP, 8'd2, 4'd5, 8'd0);
		send(ACT_DOWN, 8'd1, 4'd6, 8'd0);
		send(ACT_DOWN, 8'd1, 4'd9, 8'd0);
		send(ACT_RELEASE, 8'd0, 4'd6, 8'd0);
		send(ACT_UP, 8'd1, 4'd0, 8'd0);
		send(ACT_UNDEF_LO, 8'd1, 4'd0, 8'd0);
		send(ACT_UNDEF_HI, 8'd170, 4'd10, 8'd85);
		send(ACT_RELEASE, 8'd0, 4'd15, 8'd0);
		send(ACT_RELEASE, 8'd0, 4'd0, 8'd0);
		send(ACT_RELEASE, 8'd0, 4'd5, 8'd0);
		drain();

		// Fill the whole table, try once more with none free, then free it all.
		for (int i = 0; i < 256; i++) send(ACT_CREATE, 8'd0, i[PID_W-1:0], i[7:0]);
		for (int p = 0; p < 16; p++) send(ACT_RELEASE, 8'd0, p[PID_W-1:0], 8'd0);
		drain();

		// Random part in phases of sender idling, with a full pause midway.
		for (int ph = 0; ph < 4; ph++) begin
			idle_pct = (ph == 1) ? 52 : (ph == 3) ? 9 : 0;
			for (int i = 0; i < 215; i++) begin
				random_request();
				if (ph == 2 && i == 107) drain();
			end
		end
		drain();
		repeat (20) @(posedge clk);

		$display("Ran %0d requests and checked %0d results, including a full table,",
			issued, checked);
		$display("stale waiters, queue removal on release and four sender idling phases.");
		if (fail_count == 0) begin
			$display("[counting_semaphore_table_top] OK");
		end else begin
			$display("[counting_semaphore_table_top] ERROR");
		end
		$finish;
	end
endmodule
